[rtl/msct_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-slot countdown timer package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package msct_pkg;

    localparam int SLOTS       = 16;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int SID_W       = 4;
    localparam int PER_W       = 16;
    localparam int REM_W       = 26;
    localparam int MODE_W      = 2;
    localparam int KIND_W      = 2;
    localparam int MS_PER_S    = 1000;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

    typedef struct packed {
        logic             rep;
        logic [PER_W-1:0] per;
        logic [REM_W-1:0] rem;
    } t_slot;

    typedef struct packed {
        logic load_item;
        logic do_start;
        logic do_stop;
        logic prime;
        logic scan_step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              emit_req;
        logic              pend_valid;
        logic              last_slot;
    } t_stat;

endpackage

[rtl/msct_ctrl.sv]
// ----------------------------------------------------------------------------
// Multi-slot countdown timer controller
// Sequences decode, start, stop and the tick scan over all slots.
// ----------------------------------------------------------------------------
module msct_ctrl
    import msct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tvalid,
    output logic  o_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_STOP   = 3'd3;
    localparam logic [2:0] S_PRIME  = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_TICK:  n_state = S_PRIME;
                    MODE_START: n_state = S_START;
                    MODE_STOP:  n_state = S_STOP;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_START: begin
                if (i_stat.out_free) begin
                    o_cmd.do_start = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_STOP: begin
                if (i_stat.out_free) begin
                    o_cmd.do_stop = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                if (!(i_stat.emit_req && i_stat.pend_valid && !i_stat.out_free)) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.last_slot) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/msct_dp.sv]
// ----------------------------------------------------------------------------
// Multi-slot countdown timer datapath
// Slot memory, active bits, the reload multiplier and the result register.
// ----------------------------------------------------------------------------
module msct_dp
    import msct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [SID_W-1:0]      i_slot_id,
    input  logic [PER_W-1:0]      i_secs,
    input  logic                  i_rep,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KIND_W-1:0]     o_kind,
    output logic [SID_W-1:0]      o_slot,
    output logic                  o_success,
    output logic                  o_last
);

    t_slot r_mem [SLOTS];
    t_slot r_rd;

    logic [MODE_W-1:0] r_mode;
    logic [SID_W-1:0]  r_sid;
    logic [PER_W-1:0]  r_secs;
    logic              r_rep;

    logic [SLOTS-1:0]  r_active;
    logic [SLOTS-1:0]  n_active;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] n_idx;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [SLOT_W-1:0] n_pend_slot;
    logic              r_pend_valid;
    logic              n_pend_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_ovalid;
    logic              n_ovalid;
    logic [KIND_W-1:0] r_okind;
    logic [KIND_W-1:0] n_okind;
    logic [SID_W-1:0]  r_oslot;
    logic [SID_W-1:0]  n_oslot;
    logic              r_osucc;
    logic              n_osucc;
    logic              r_olast;
    logic              n_olast;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    t_slot             wr_data;

    logic [PER_W-1:0]  mul_in;
    logic [REM_W-1:0]  mul_res;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              out_free;
    logic              emit_req;
    logic              stop_ok;

    assign out_free = !r_ovalid || i_ready;
    assign mul_in   = i_cmd.scan_step ? r_rd.per : r_secs;
    assign mul_res  = REM_W'(REM_W'(mul_in) * REM_W'(MS_PER_S));
    assign emit_req = r_active[r_idx] && (r_rd.rem == '0)
                      && (r_count < CNT_W'(MAX_RESULTS));
    assign stop_ok  = (32'(r_sid) < SLOTS) && r_active[SLOT_W'(r_sid)];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        if (i_cmd.prime) begin
            rd_addr = '0;
        end else if (i_cmd.scan_step) begin
            rd_addr = SLOT_W'(r_idx + SLOT_W'(1));
        end else begin
            rd_addr = r_idx;
        end
    end

    always_comb begin
        n_active     = r_active;
        n_idx        = r_idx;
        n_pend_slot  = r_pend_slot;
        n_pend_valid = r_pend_valid;
        n_count      = r_count;
        n_ovalid     = r_ovalid && !i_ready;
        n_okind      = r_okind;
        n_oslot      = r_oslot;
        n_osucc      = r_osucc;
        n_olast      = r_olast;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = r_rd;

        if (i_cmd.do_start) begin
            n_ovalid = 1'b1;
            n_okind  = KIND_START;
            n_osucc  = free_found;
            n_olast  = 1'b1;
            n_oslot  = free_found ? SID_W'(free_idx) : '0;
            if (free_found) begin
                n_active[free_idx] = 1'b1;
                wr_en              = 1'b1;
                wr_addr            = free_idx;
                wr_data.rep        = r_rep;
                wr_data.per        = r_secs;
                wr_data.rem        = mul_res;
            end
        end

        if (i_cmd.do_stop) begin
            n_ovalid = 1'b1;
            n_okind  = KIND_STOP;
            n_oslot  = r_sid;
            n_osucc  = stop_ok;
            n_olast  = 1'b1;
            if (stop_ok) begin
                n_active[SLOT_W'(r_sid)] = 1'b0;
            end
        end

        if (i_cmd.prime) begin
            n_idx        = '0;
            n_pend_valid = 1'b0;
            n_count      = '0;
        end

        if (i_cmd.scan_step) begin
            n_idx = SLOT_W'(r_idx + SLOT_W'(1));
            if (r_active[r_idx]) begin
                if (r_rd.rem == '0) begin
                    if (emit_req) begin
                        if (r_pend_valid) begin
                            n_ovalid = 1'b1;
                            n_okind  = KIND_EXPIRE;
                            n_oslot  = SID_W'(r_pend_slot);
                            n_osucc  = 1'b1;
                            n_olast  = 1'b0;
                        end
                        n_pend_slot  = r_idx;
                        n_pend_valid = 1'b1;
                        n_count      = CNT_W'(r_count + CNT_W'(1));
                        if (r_rd.rep) begin
                            wr_en       = 1'b1;
                            wr_data.rem = mul_res;
                        end else begin
                            n_active[r_idx] = 1'b0;
                        end
                    end
                end else begin
                    wr_en       = 1'b1;
                    wr_data.rem = r_rd.rem - REM_W'(1);
                end
            end
        end

        if (i_cmd.flush) begin
            n_ovalid     = 1'b1;
            n_okind      = KIND_EXPIRE;
            n_oslot      = SID_W'(r_pend_slot);
            n_osucc      = 1'b1;
            n_olast      = 1'b1;
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_sid  <= i_slot_id;
            r_secs <= i_secs;
            r_rep  <= i_rep;
        end
        r_okind     <= n_okind;
        r_oslot     <= n_oslot;
        r_osucc     <= n_osucc;
        r_olast     <= n_olast;
        r_pend_slot <= n_pend_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_active     <= n_active;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_ovalid     <= n_ovalid;
        end
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.out_free   = out_free;
    assign o_stat.emit_req   = emit_req;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.last_slot  = (r_idx == SLOT_W'(SLOTS - 1));

    assign o_valid   = r_ovalid;
    assign o_kind    = r_okind;
    assign o_slot    = r_oslot;
    assign o_success = r_osucc;
    assign o_last    = r_olast;

endmodule

[rtl/multi_slot_countdown_timer.sv]
// ----------------------------------------------------------------------------
// Multi-slot countdown timer bank
// Start and stop answers are loaded into the result register after the input
// beat is decoded, once the output is free; a new item is taken only when the
// last one is done. A tick scans one slot per cycle unless a held result beat stalls it.
// The scan rate is set by the single read port of the slot memory.
// Reset is synchronous and clears all active bits and the control state.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer
    import msct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0: slot_id[3:0], interval_seconds[19:4], repeat_flag[20].
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [MODE_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Fields from bit 0: slot_out[3:0], success[4].
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // Fields from bit 0: event_kind[1:0].
    output logic [KIND_W-1:0]     o_m_tuser,
    output logic                  o_m_tlast
);

    t_cmd             cmd;
    t_stat            stat;
    logic [SID_W-1:0] out_slot;
    logic             out_success;

    msct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    msct_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_mode    (i_s_tuser),
        .i_slot_id (i_s_tdata[SID_W-1:0]),
        .i_secs    (i_s_tdata[SID_W+PER_W-1:SID_W]),
        .i_rep     (i_s_tdata[SID_W+PER_W]),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (o_m_tuser),
        .o_slot    (out_slot),
        .o_success (out_success),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {{(OUT_DATA_W - SID_W - 1){1'b0}}, out_success, out_slot};

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_item, cmd.do_start, cmd.do_stop, cmd.prime,
                  cmd.scan_step, cmd.flush}))
        else $error("more than one datapath command in a cycle");

    a_answer_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.do_start || cmd.do_stop || cmd.flush) |-> stat.out_free)
        else $error("answer loaded while result register is held");

    a_expire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan_step && stat.emit_req && stat.pend_valid) |-> stat.out_free)
        else $error("expiry event loaded while result register is held");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |=> !stat.pend_valid)
        else $error("pending expiry not cleared by flush");

endmodule
